### hdl/clr_pkg.sv
`timescale 1ns / 1ps
package clr_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;

  localparam int unsigned WIDTH_REG_W  = 11;
  localparam int unsigned HEIGHT_REG_W = 11;
  localparam int unsigned PITCH_REG_W  = 13;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned OFFSET_W     = 23;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = 11'd240;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 11'd320;
  localparam logic [PITCH_REG_W-1:0]  PITCH_RST  = 13'd480;

  localparam logic [CFG_IDX_W-1:0] REG_SURFACE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SURFACE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH      = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

endpackage

### hdl/clr_step.sv
`timescale 1ns / 1ps
module clr_step import clr_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         in_opcode_i,
  input  logic signed [COORD_BITS-1:0] in_start_x_i,
  input  logic signed [COORD_BITS-1:0] in_start_y_i,
  input  logic signed [COORD_BITS-1:0] in_end_x_i,
  input  logic signed [COORD_BITS-1:0] in_end_y_i,
  output logic                         pix_valid_o,
  input  logic                         pix_ready_i,
  output logic signed [COORD_BITS-1:0] pix_x_o,
  output logic signed [COORD_BITS-1:0] pix_y_o,
  output logic                         pix_last_o
);

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned ERR_W = COORD_BITS + 3;

  logic                 busy_q, busy_d;
  logic signed [CB-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [CB-1:0] tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic                 dxn_q, dxn_d, dyn_q, dyn_d;
  logic [CB:0]          tdx_q, tdx_d, tdy_q, tdy_d;
  logic                 xmaj_q, xmaj_d;
  logic signed [ERR_W-1:0] err_q, err_d;
  logic                 last_q, last_d;
  logic                 valid_q, valid_d;

  logic                 accept;
  logic signed [CB:0]   dx, dy;
  logic [CB:0]          dx_neg, dy_neg;
  logic [CB-1:0]        adx, ady;
  logic [CB:0]          ld_tdx, ld_tdy;
  logic                 ld_xmaj;

  logic                 adv_minor;
  logic [CB:0]          maj_t, min_t;
  logic signed [CB-1:0] st_x, st_y;
  logic                 st_last;

  assign in_ready_o = !valid_q || pix_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // load: deltas, directions and initial error
  assign dx      = {in_end_x_i[CB-1], in_end_x_i} - {in_start_x_i[CB-1], in_start_x_i};
  assign dy      = {in_end_y_i[CB-1], in_end_y_i} - {in_start_y_i[CB-1], in_start_y_i};
  assign dx_neg  = -dx;
  assign dy_neg  = -dy;
  assign adx     = dx[CB] ? dx_neg[CB-1:0] : dx[CB-1:0];
  assign ady     = dy[CB] ? dy_neg[CB-1:0] : dy[CB-1:0];
  assign ld_tdx  = {adx, 1'b0};
  assign ld_tdy  = {ady, 1'b0};
  assign ld_xmaj = ld_tdx >= ld_tdy;

  // step: symmetric tie-break favors the minor move when the major axis runs positive
  assign adv_minor = (err_q > 0) ||
                     ((err_q == 0) && !(xmaj_q ? dxn_q : dyn_q));
  assign maj_t = xmaj_q ? tdx_q : tdy_q;
  assign min_t = xmaj_q ? tdy_q : tdx_q;
  assign st_x  = (xmaj_q || adv_minor) ? (dxn_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1) : cur_x_q;
  assign st_y  = (!xmaj_q || adv_minor) ? (dyn_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1) : cur_y_q;
  assign st_last = xmaj_q ? (st_x == tgt_x_q) : (st_y == tgt_y_q);

  always_comb begin
    busy_d  = busy_q;
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    tgt_x_d = tgt_x_q;
    tgt_y_d = tgt_y_q;
    dxn_d   = dxn_q;
    dyn_d   = dyn_q;
    tdx_d   = tdx_q;
    tdy_d   = tdy_q;
    xmaj_d  = xmaj_q;
    err_d   = err_q;
    last_d  = last_q;
    valid_d = valid_q && !pix_ready_i;
    if (accept) begin
      if (in_opcode_i == OP_LOAD) begin
        dxn_d   = !(in_end_x_i > in_start_x_i);
        dyn_d   = !(in_end_y_i > in_start_y_i);
        tdx_d   = ld_tdx;
        tdy_d   = ld_tdy;
        xmaj_d  = ld_xmaj;
        if (ld_xmaj) begin
          err_d = $signed({2'b00, ld_tdy}) - $signed({3'b000, adx});
        end else begin
          err_d = $signed({2'b00, ld_tdx}) - $signed({3'b000, ady});
        end
        cur_x_d = in_start_x_i;
        cur_y_d = in_start_y_i;
        tgt_x_d = in_end_x_i;
        tgt_y_d = in_end_y_i;
        last_d  = ld_xmaj ? (in_start_x_i == in_end_x_i) : (in_start_y_i == in_end_y_i);
        busy_d  = !last_d;
        valid_d = 1'b1;
      end else if (busy_q) begin
        cur_x_d = st_x;
        cur_y_d = st_y;
        err_d   = err_q + $signed({2'b00, min_t})
                  - (adv_minor ? $signed({2'b00, maj_t}) : $signed(ERR_W'(0)));
        last_d  = st_last;
        busy_d  = !st_last;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cur_x_q <= '0;
      cur_y_q <= '0;
      tgt_x_q <= '0;
      tgt_y_q <= '0;
      dxn_q   <= 1'b0;
      dyn_q   <= 1'b0;
      tdx_q   <= '0;
      tdy_q   <= '0;
      xmaj_q  <= 1'b0;
      err_q   <= '0;
      last_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      tgt_x_q <= tgt_x_d;
      tgt_y_q <= tgt_y_d;
      dxn_q   <= dxn_d;
      dyn_q   <= dyn_d;
      tdx_q   <= tdx_d;
      tdy_q   <= tdy_d;
      xmaj_q  <= xmaj_d;
      err_q   <= err_d;
      last_q  <= last_d;
      valid_q <= valid_d;
    end
  end

  assign pix_valid_o = valid_q;
  assign pix_x_o     = cur_x_q;
  assign pix_y_o     = cur_y_q;
  assign pix_last_o  = last_q;

endmodule

### hdl/clr_emit.sv
`timescale 1ns / 1ps
module clr_emit import clr_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [WIDTH_REG_W-1:0]       width_i,
  input  logic [HEIGHT_REG_W-1:0]      height_i,
  input  logic [PITCH_REG_W-1:0]       pitch_i,
  input  logic                         pix_valid_i,
  output logic                         pix_ready_o,
  input  logic signed [COORD_BITS-1:0] pix_x_i,
  input  logic signed [COORD_BITS-1:0] pix_y_i,
  input  logic                         pix_last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0] out_x_o,
  output logic signed [COORD_BITS-1:0] out_y_o,
  output logic                         out_we_o,
  output logic [OFFSET_W-1:0]          out_offset_o,
  output logic                         out_last_o
);

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned MAG_W = COORD_BITS - 1;
  localparam int unsigned CMP_W = (MAG_W > WIDTH_REG_W) ? MAG_W : WIDTH_REG_W;
  localparam int unsigned MUL_W = MAG_W + PITCH_REG_W;

  logic                 valid_q;
  logic signed [CB-1:0] x_q, y_q;
  logic                 we_q, last_q;
  logic [OFFSET_W-1:0]  off_q;

  logic [MAG_W-1:0]     x_mag, y_mag;
  logic                 in_bounds;
  logic [MUL_W-1:0]     row_base;
  logic [OFFSET_W-1:0]  offset;
  logic                 load;

  assign x_mag  = pix_x_i[MAG_W-1:0];
  assign y_mag  = pix_y_i[MAG_W-1:0];
  assign in_bounds = !pix_x_i[CB-1] && !pix_y_i[CB-1] &&
                     (CMP_W'(x_mag) < CMP_W'(width_i)) &&
                     (CMP_W'(y_mag) < CMP_W'(height_i));
  assign row_base = MUL_W'(y_mag) * MUL_W'(pitch_i);
  assign offset   = OFFSET_W'(row_base) + OFFSET_W'({x_mag, 1'b0});

  assign pix_ready_o = !valid_q || out_ready_i;
  assign load        = pix_valid_i && pix_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pix_ready_o) begin
      valid_q <= pix_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q    <= pix_x_i;
      y_q    <= pix_y_i;
      we_q   <= in_bounds;
      off_q  <= in_bounds ? offset : '0;
      last_q <= pix_last_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_x_o      = x_q;
  assign out_y_o      = y_q;
  assign out_we_o     = we_q;
  assign out_offset_o = off_q;
  assign out_last_o   = last_q;

endmodule

### hdl/clipped_line_rasterizer.sv
`timescale 1ns / 1ps
// Bresenham line rasterizer with surface clipping. A load beat (tuser = 0) latches
// both endpoints and yields the start pixel; each step beat (tuser = 1) yields the
// next pixel until the end point, which carries tlast. A step while no line is
// active is consumed without output. Throughput is one beat per clock unless
// m_axis_tready back-pressure stalls it: the step update is a single add/compare
// pass in clr_step, and clip plus the y * pitch + 2x address multiply sit in
// clr_emit, each with an output register. Config writes are only legal while idle.
module clipped_line_rasterizer import clr_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]               cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // start_x, start_y, end_x, end_y, zero pad
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]   s_axis_tdata,
  // opcode
  input  logic [0:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // pixel_x, pixel_y, byte_offset, zero pad
  output logic [((2*COORD_BITS+OFFSET_W+7)/8)*8-1:0] m_axis_tdata,
  // write_enable
  output logic [0:0]                          m_axis_tuser,
  output logic                                m_axis_tlast
);

  localparam int unsigned CB       = COORD_BITS;
  localparam int unsigned OUT_W    = ((2*COORD_BITS+OFFSET_W+7)/8)*8;

  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  logic [PITCH_REG_W-1:0]  pitch_q;

  logic                 pix_valid, pix_ready, pix_last;
  logic signed [CB-1:0] pix_x, pix_y;
  logic signed [CB-1:0] out_x, out_y;
  logic [OFFSET_W-1:0]  out_offset;
  logic                 out_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      pitch_q  <= PITCH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SURFACE_WIDTH:  width_q  <= cfg_data_i[WIDTH_REG_W-1:0];
        REG_SURFACE_HEIGHT: height_q <= cfg_data_i[HEIGHT_REG_W-1:0];
        REG_ROW_PITCH:      pitch_q  <= cfg_data_i[PITCH_REG_W-1:0];
        default: ;
      endcase
    end
  end

  clr_step #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_opcode_i  (s_axis_tuser[0]),
    .in_start_x_i (s_axis_tdata[CB-1:0]),
    .in_start_y_i (s_axis_tdata[2*CB-1:CB]),
    .in_end_x_i   (s_axis_tdata[3*CB-1:2*CB]),
    .in_end_y_i   (s_axis_tdata[4*CB-1:3*CB]),
    .pix_valid_o  (pix_valid),
    .pix_ready_i  (pix_ready),
    .pix_x_o      (pix_x),
    .pix_y_o      (pix_y),
    .pix_last_o   (pix_last)
  );

  clr_emit #(
    .COORD_BITS(COORD_BITS)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .width_i      (width_q),
    .height_i     (height_q),
    .pitch_i      (pitch_q),
    .pix_valid_i  (pix_valid),
    .pix_ready_o  (pix_ready),
    .pix_x_i      (pix_x),
    .pix_y_i      (pix_y),
    .pix_last_i   (pix_last),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_x_o      (out_x),
    .out_y_o      (out_y),
    .out_we_o     (out_we),
    .out_offset_o (out_offset),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_W'({out_offset, out_y, out_x});
  assign m_axis_tuser = out_we;

endmodule
